// ===== rtl/pmf_pkg.sv =====
package pmf_pkg;

	localparam int DATA_W    = 32;
	localparam int OUT_IDX_W = 5;

	typedef enum logic [3:0] {
		ST_LOAD   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_FETCH  = 4'b0100,
		ST_SEND   = 4'b1000
	} state_t;

endpackage

// ===== rtl/pmf_cell.sv =====
module pmf_cell import pmf_pkg::*; #(
	parameter int IDX = 0,
	parameter int IW  = 5,
	parameter int CW  = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ld_en,
	input  logic [IW-1:0]     ld_idx,
	input  logic [DATA_W-1:0] ld_b,
	input  logic              clr,
	input  logic [CW-1:0]     n,
	input  logic              in_valid,
	input  logic [DATA_W-1:0] in_a,
	input  logic [IW-1:0]     in_idx,
	input  logic              in_found,
	input  logic [IW-1:0]     in_fwd,
	output logic              out_valid,
	output logic [DATA_W-1:0] out_a,
	output logic [IW-1:0]     out_idx,
	output logic              out_found,
	output logic [IW-1:0]     out_fwd,
	input  logic              shift,
	input  logic [IW-1:0]     nxt_bwd,
	input  logic              nxt_seen,
	output logic [IW-1:0]     bwd,
	output logic              seen
);

	logic [DATA_W-1:0] b_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_a_q;
	logic [IW-1:0]     out_idx_q;
	logic              out_found_q;
	logic [IW-1:0]     out_fwd_q;
	logic [IW-1:0]     bwd_q;
	logic              seen_q;
	logic              active;
	logic              hit;

	assign active = CW'(IDX) < n;
	assign hit    = in_valid && !in_found && active && (b_q == in_a);

	always_ff @(posedge clk) begin
		if (ld_en && (ld_idx == IW'(IDX))) begin
			b_q <= ld_b;
		end
		out_a_q     <= in_a;
		out_idx_q   <= in_idx;
		out_found_q <= in_found || hit;
		out_fwd_q   <= hit ? IW'(IDX) : in_fwd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			bwd_q       <= '0;
			seen_q      <= 1'b0;
		end else begin
			out_valid_q <= in_valid;
			if (clr) begin
				bwd_q  <= '0;
				seen_q <= 1'b0;
			end else if (shift) begin
				bwd_q  <= nxt_bwd;
				seen_q <= nxt_seen;
			end else if (hit) begin
				bwd_q  <= in_idx;
				seen_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_a     = out_a_q;
	assign out_idx   = out_idx_q;
	assign out_found = out_found_q;
	assign out_fwd   = out_fwd_q;
	assign bwd       = bwd_q;
	assign seen      = seen_q;

endmodule

// ===== rtl/permutation_match_finder.sv =====
// Loading takes one pair per cycle; the pair with tlast, or the one filling slot
// MAX_LENGTH-1, starts the search. In search, one query per cycle enters a chain
// of MAX_LENGTH compare cells and leaves its end. Each result is read from the
// forward map (ST_FETCH), then sent (ST_SEND); a failure gives a single result.
// No pair is taken between the final pair and the last result.
// arst_n clears control state and the backward maps; the value stores stay undefined.
module permutation_match_finder import pmf_pkg::*; #(
	parameter int MAX_LENGTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // value_a[31:0], value_b[63:32]
	input  logic        s_tlast,  // final_pair
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // position[4:0], forward_index[9:5],
	                              // backward_index[14:10], backward_valid[15]
	output logic        m_tuser,  // matched_all
	output logic        m_tlast   // end_of_run
);

	localparam int IW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int CW = $clog2(MAX_LENGTH + 1);

	state_t            state_q;
	logic [IW-1:0]     ld_idx_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     iss_q;
	logic              iss_valid_s1;
	logic [IW-1:0]     iss_idx_s1;
	logic [DATA_W-1:0] a_rd_s1;
	logic              fail_q;
	logic [IW-1:0]     fail_pos_q;
	logic [IW-1:0]     k_q;
	logic [IW-1:0]     fwd_rd_q;

	logic [DATA_W-1:0] a_mem   [MAX_LENGTH];
	logic [IW-1:0]     fwd_mem [MAX_LENGTH];

	logic              ch_valid [MAX_LENGTH+1];
	logic [DATA_W-1:0] ch_a     [MAX_LENGTH+1];
	logic [IW-1:0]     ch_idx   [MAX_LENGTH+1];
	logic              ch_found [MAX_LENGTH+1];
	logic [IW-1:0]     ch_fwd   [MAX_LENGTH+1];
	logic [IW-1:0]     sh_bwd   [MAX_LENGTH+1];
	logic              sh_seen  [MAX_LENGTH+1];

	logic ld_acc;
	logic ld_last;
	logic clr;
	logic issue;
	logic tail_last;
	logic out_acc;
	logic k_last;

	assign s_tready  = (state_q == ST_LOAD);
	assign ld_acc    = s_tvalid && s_tready;
	assign ld_last   = s_tlast || (ld_idx_q == IW'(MAX_LENGTH - 1));
	assign clr       = ld_acc && ld_last;
	assign issue     = (state_q == ST_SEARCH) && (iss_q < n_q);
	assign tail_last = ch_valid[MAX_LENGTH] && (ch_idx[MAX_LENGTH] == IW'(n_q - CW'(1)));
	assign m_tvalid  = (state_q == ST_SEND);
	assign out_acc   = m_tvalid && m_tready;
	assign k_last    = (CW'(k_q) == (n_q - CW'(1)));

	assign ch_valid[0] = iss_valid_s1;
	assign ch_a[0]     = a_rd_s1;
	assign ch_idx[0]   = iss_idx_s1;
	assign ch_found[0] = 1'b0;
	assign ch_fwd[0]   = '0;

	assign sh_bwd[MAX_LENGTH]  = '0;
	assign sh_seen[MAX_LENGTH] = 1'b0;

	for (genvar g = 0; g < MAX_LENGTH; g++) begin : g_chain
		pmf_cell #(
			.IDX(g),
			.IW (IW),
			.CW (CW)
		) u_node (
			.clk      (clk),
			.arst_n   (arst_n),
			.ld_en    (ld_acc),
			.ld_idx   (ld_idx_q),
			.ld_b     (s_tdata[63:32]),
			.clr      (clr),
			.n        (n_q),
			.in_valid (ch_valid[g]),
			.in_a     (ch_a[g]),
			.in_idx   (ch_idx[g]),
			.in_found (ch_found[g]),
			.in_fwd   (ch_fwd[g]),
			.out_valid(ch_valid[g+1]),
			.out_a    (ch_a[g+1]),
			.out_idx  (ch_idx[g+1]),
			.out_found(ch_found[g+1]),
			.out_fwd  (ch_fwd[g+1]),
			.shift    (out_acc),
			.nxt_bwd  (sh_bwd[g+1]),
			.nxt_seen (sh_seen[g+1]),
			.bwd      (sh_bwd[g]),
			.seen     (sh_seen[g])
		);
	end

	always_ff @(posedge clk) begin
		if (ld_acc) begin
			a_mem[ld_idx_q] <= s_tdata[31:0];
		end
		a_rd_s1 <= a_mem[iss_q[IW-1:0]];
		if (ch_valid[MAX_LENGTH] && ch_found[MAX_LENGTH]) begin
			fwd_mem[ch_idx[MAX_LENGTH]] <= ch_fwd[MAX_LENGTH];
		end
		fwd_rd_q <= fwd_mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			ld_idx_q     <= '0;
			n_q          <= '0;
			iss_q        <= '0;
			iss_valid_s1 <= 1'b0;
			iss_idx_s1   <= '0;
			fail_q       <= 1'b0;
			fail_pos_q   <= '0;
			k_q          <= '0;
		end else begin
			iss_valid_s1 <= issue;
			iss_idx_s1   <= iss_q[IW-1:0];
			case (state_q)
				ST_LOAD: begin
					if (ld_acc) begin
						if (ld_last) begin
							n_q      <= CW'(ld_idx_q) + CW'(1);
							ld_idx_q <= '0;
							iss_q    <= '0;
							fail_q   <= 1'b0;
							state_q  <= ST_SEARCH;
						end else begin
							ld_idx_q <= ld_idx_q + IW'(1);
						end
					end
				end
				ST_SEARCH: begin
					if (issue) begin
						iss_q <= iss_q + CW'(1);
					end
					if (ch_valid[MAX_LENGTH] && !ch_found[MAX_LENGTH] && !fail_q) begin
						fail_q     <= 1'b1;
						fail_pos_q <= ch_idx[MAX_LENGTH];
					end
					if (tail_last) begin
						k_q     <= '0;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_acc) begin
						if (m_tlast) begin
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + IW'(1);
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_tuser       = !fail_q;
	assign m_tlast       = fail_q || k_last;
	assign m_tdata[4:0]  = fail_q ? OUT_IDX_W'(fail_pos_q) : OUT_IDX_W'(k_q);
	assign m_tdata[9:5]  = fail_q ? '0 : OUT_IDX_W'(fwd_rd_q);
	assign m_tdata[14:10] = fail_q ? '0 : OUT_IDX_W'(sh_bwd[0]);
	assign m_tdata[15]   = !fail_q && sh_seen[0];

endmodule

// ===== tb/permutation_match_finder_tb.sv =====
module permutation_match_finder_tb import pmf_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN = 32;
	localparam int PHASE_PAIRS = 64;

	typedef logic [DATA_W-1:0]    word_t;
	typedef logic [OUT_IDX_W-1:0] index_t;

	typedef struct packed {
		logic   matched_all;
		index_t position;
		index_t forward_index;
		index_t backward_index;
		logic   backward_valid;
		logic   end_of_run;
	} match_result_t;

	class match_board;
		word_t           first_vals[MAX_LEN];
		word_t           second_vals[MAX_LEN];
		int              fill;
		match_result_t   expected_results[$];
		int              mismatch_count;

		function new();
			fill = 0;
			mismatch_count = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void note_pair(word_t a, word_t b, logic last);
			index_t        fwd[MAX_LEN];
			index_t        bwd[MAX_LEN];
			logic          seen[MAX_LEN];
			logic          found;
			int            n;
			match_result_t r;
			first_vals[fill] = a;
			second_vals[fill] = b;
			fill++;
			if (!last && fill < MAX_LEN)
				return;
			n = fill;
			fill = 0;
			for (int j = 0; j < MAX_LEN; j++) begin
				fwd[j] = '0;
				bwd[j] = '0;
				seen[j] = 1'b0;
			end
			for (int i = 0; i < n; i++) begin
				found = 1'b0;
				for (int j = 0; j < n && !found; j++) begin
					if (second_vals[j] == first_vals[i]) begin
						fwd[i] = index_t'(j);
						bwd[j] = index_t'(i);
						seen[j] = 1'b1;
						found = 1'b1;
					end
				end
				if (!found) begin
					r = '{1'b0, index_t'(i), '0, '0, 1'b0, 1'b1};
					expected_results.push_back(r);
					return;
				end
			end
			for (int i = 0; i < n; i++) begin
				r = '{1'b1, index_t'(i), fwd[i], bwd[i], seen[i], logic'(i == n - 1)};
				expected_results.push_back(r);
			end
		endfunction

		function void check_result(match_result_t got);
			match_result_t exp;
			if (expected_results.size() == 0) begin
				$error("result with nothing pending: position %0d", got.position);
				mismatch_count++;
				return;
			end
			exp = expected_results.pop_front();
			if (got.matched_all !== exp.matched_all) begin
				$error("matched_all: expected %0d, got %0d", exp.matched_all, got.matched_all);
				mismatch_count++;
			end
			if (got.position !== exp.position) begin
				$error("position: expected %0d, got %0d", exp.position, got.position);
				mismatch_count++;
			end
			if (got.forward_index !== exp.forward_index) begin
				$error("forward_index: expected %0d, got %0d",
					exp.forward_index, got.forward_index);
				mismatch_count++;
			end
			if (got.backward_index !== exp.backward_index) begin
				$error("backward_index: expected %0d, got %0d",
					exp.backward_index, got.backward_index);
				mismatch_count++;
			end
			if (got.backward_valid !== exp.backward_valid) begin
				$error("backward_valid: expected %0d, got %0d",
					exp.backward_valid, got.backward_valid);
				mismatch_count++;
			end
			if (got.end_of_run !== exp.end_of_run) begin
				$error("end_of_run: expected %0d, got %0d", exp.end_of_run, got.end_of_run);
				mismatch_count++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	match_board sb = new();
	int         src_idle_pct = 0;
	int         snk_idle_pct = 0;
	int         pairs_sent = 0;
	word_t      vec_a[MAX_LEN];
	word_t      vec_b[MAX_LEN];

	permutation_match_finder #(.MAX_LENGTH(MAX_LEN)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result('{m_tuser, m_tdata[4:0], m_tdata[9:5], m_tdata[14:10],
				m_tdata[15], m_tlast});
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	function automatic word_t pick_value();
		return ($urandom_range(3) == 0) ? word_t'($urandom_range(3)) : word_t'($urandom);
	endfunction

	task automatic send_pair(input word_t a, input word_t b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_pair(a, b, last);
		pairs_sent++;
	endtask

	task automatic send_vector(input int n, input bit flag_end);
		for (int i = 0; i < n; i++)
			send_pair(vec_a[i], vec_b[i], flag_end && (i == n - 1));
	endtask

	task automatic random_run(input int n, input bit flag_end);
		int    style;
		int    k;
		word_t t;
		style = $urandom_range(99);
		for (int i = 0; i < n; i++) begin
			vec_a[i] = pick_value();
			vec_b[i] = vec_a[i];
		end
		for (int i = n - 1; i > 0; i--) begin
			k = $urandom_range(i);
			t = vec_b[i];
			vec_b[i] = vec_b[k];
			vec_b[k] = t;
		end
		if (style >= 70 && style < 85) begin
			for (int i = 0; i < n; i++)
				vec_b[i] = vec_a[$urandom_range(n - 1)];
		end else if (style >= 85) begin
			for (int i = $urandom_range(1, 3); i > 0; i--)
				vec_b[$urandom_range(n - 1)] = pick_value();
		end
		send_vector(n, flag_end);
	endtask

	initial begin
		int start;
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 12;
		snk_idle_pct = 74;

		vec_a[0] = 32'h8000_0000;
		vec_b[0] = 32'h8000_0000;
		send_vector(1, 1'b1);

		vec_a[0] = 32'h7fff_ffff;
		vec_b[0] = 32'h0000_0000;
		send_vector(1, 1'b1);

		vec_a[0] = 32'h0000_0000;
		vec_a[1] = 32'hffff_ffff;
		vec_a[2] = 32'h7fff_ffff;
		vec_a[3] = 32'h8000_0000;
		vec_b[0] = 32'h8000_0000;
		vec_b[1] = 32'h0000_0000;
		vec_b[2] = 32'h7fff_ffff;
		vec_b[3] = 32'hffff_ffff;
		send_vector(4, 1'b1);

		// repeated values: later matches overwrite, unused slots stay unmatched
		vec_a[0] = 32'd5;
		vec_a[1] = 32'd5;
		vec_a[2] = 32'd5;
		vec_b[0] = 32'd5;
		vec_b[1] = 32'd7;
		vec_b[2] = 32'd9;
		send_vector(3, 1'b1);

		vec_a[0] = 32'd1;
		vec_a[1] = 32'd2;
		vec_a[2] = 32'd3;
		vec_a[3] = 32'd4;
		vec_b[0] = 32'd4;
		vec_b[1] = 32'd3;
		vec_b[2] = 32'd9;
		vec_b[3] = 32'd1;
		send_vector(4, 1'b1);

		for (int p = 0; p < 3; p++) begin
			src_idle_pct = (p == 0) ? 12 : (p == 1) ? 74 : 0;
			snk_idle_pct = (p == 0) ? 74 : (p == 1) ? 12 : 0;
			start = pairs_sent;
			// full-length run; the flag on the last pair alternates per phase
			random_run(MAX_LEN, p == 1);
			while (pairs_sent - start < PHASE_PAIRS) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(9, MAX_LEN - 1)
					: $urandom_range(1, 8);
				random_run(n, 1'b1);
			end
			s_tvalid <= 1'b0;
			while (sb.pending() != 0)
				@(posedge clk);
		end

		repeat (4 * MAX_LEN + 20) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
